// ----- design/csct_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csct_pkg
// Shared widths, codes and the arctangent table for the CORDIC sine, cosine
// and tangent unit.
// ----------------------------------------------------------------------------
package csct_pkg;

  localparam int XY_W       = 34;
  localparam int Z_W        = 34;
  localparam int NUM_W      = XY_W + 16;
  localparam int TABLE_LEN  = 31;
  localparam int ITERATIONS_DEF = 30;

  localparam logic signed [XY_W-1:0] GAIN_Q30 = 34'sd652032874;

  localparam logic [1:0] KIND_SIN = 2'd0;
  localparam logic [1:0] KIND_COS = 2'd1;
  localparam logic [1:0] KIND_TAN = 2'd2;

  localparam logic signed [31:0] I32_MAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] I32_MIN = 32'sh80000000;

  typedef struct packed {
    logic              valid;
    logic [1:0]        kind;
    logic              q_neg;
    logic              x_zero;
    logic signed [31:0] trig;
  } side_t;

  function automatic logic signed [Z_W-1:0] atan_q30(input logic [4:0] idx);
    logic signed [Z_W-1:0] r;
    unique case (idx)
      5'd0:  r = 34'sd843314857;
      5'd1:  r = 34'sd497837829;
      5'd2:  r = 34'sd263043837;
      5'd3:  r = 34'sd133525159;
      5'd4:  r = 34'sd67021687;
      5'd5:  r = 34'sd33543516;
      5'd6:  r = 34'sd16775851;
      5'd7:  r = 34'sd8388437;
      5'd8:  r = 34'sd4194283;
      5'd9:  r = 34'sd2097149;
      5'd10: r = 34'sd1048576;
      5'd11: r = 34'sd524288;
      5'd12: r = 34'sd262144;
      5'd13: r = 34'sd131072;
      5'd14: r = 34'sd65536;
      5'd15: r = 34'sd32768;
      5'd16: r = 34'sd16384;
      5'd17: r = 34'sd8192;
      5'd18: r = 34'sd4096;
      5'd19: r = 34'sd2048;
      5'd20: r = 34'sd1024;
      5'd21: r = 34'sd512;
      5'd22: r = 34'sd256;
      5'd23: r = 34'sd128;
      5'd24: r = 34'sd64;
      5'd25: r = 34'sd32;
      5'd26: r = 34'sd16;
      5'd27: r = 34'sd8;
      5'd28: r = 34'sd4;
      5'd29: r = 34'sd2;
      5'd30: r = 34'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- design/csct_cordic.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csct_cordic
// Unrolled rotation-mode CORDIC, one register stage per iteration.
// ----------------------------------------------------------------------------
module csct_cordic #(
  parameter int ITERATIONS = csct_pkg::ITERATIONS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             en,
  input  wire logic                             in_valid,
  input  wire logic [1:0]                       in_kind,
  input  wire logic signed [31:0]               in_angle,
  input  wire logic                             in_negate,
  output logic                                  res_valid,
  output logic [1:0]                            res_kind,
  output logic                                  res_negate,
  output logic signed [csct_pkg::XY_W-1:0]      res_x,
  output logic signed [csct_pkg::XY_W-1:0]      res_y
);
  import csct_pkg::*;

  logic                   vld [0:ITERATIONS];
  logic [1:0]             knd [0:ITERATIONS];
  logic                   ngt [0:ITERATIONS];
  logic signed [XY_W-1:0] x   [0:ITERATIONS];
  logic signed [XY_W-1:0] y   [0:ITERATIONS];
  logic signed [Z_W-1:0]  z   [0:ITERATIONS];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      knd[0] <= in_kind;
      ngt[0] <= in_negate;
      x[0]   <= GAIN_Q30;
      y[0]   <= '0;
      z[0]   <= {in_angle[31], in_angle, 1'b0};
    end
  end

  for (genvar g = 0; g < ITERATIONS; g++) begin : g_stage
    localparam logic signed [Z_W-1:0] ATAN = atan_q30(5'(g));

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g+1] <= 1'b0;
      end else if (en) begin
        vld[g+1] <= vld[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        knd[g+1] <= knd[g];
        ngt[g+1] <= ngt[g];
        if (!z[g][Z_W-1]) begin
          x[g+1] <= x[g] - (y[g] >>> g);
          y[g+1] <= y[g] + (x[g] >>> g);
          z[g+1] <= z[g] - ATAN;
        end else begin
          x[g+1] <= x[g] + (y[g] >>> g);
          y[g+1] <= y[g] - (x[g] >>> g);
          z[g+1] <= z[g] + ATAN;
        end
      end
    end
  end

  assign res_valid  = vld[ITERATIONS];
  assign res_kind   = knd[ITERATIONS];
  assign res_negate = ngt[ITERATIONS];
  assign res_x      = x[ITERATIONS];
  assign res_y      = y[ITERATIONS];

endmodule
`default_nettype wire

// ----- design/csct_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csct_div
// Pipelined restoring divider for unsigned magnitudes, one quotient bit per
// stage, carrying the side information of each beat alongside.
// ----------------------------------------------------------------------------
module csct_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        en,
  input  wire csct_pkg::side_t             in_side,
  input  wire logic [csct_pkg::NUM_W-1:0]  in_num,
  input  wire logic [csct_pkg::XY_W-1:0]   in_den,
  output csct_pkg::side_t                  res_side,
  output logic [csct_pkg::NUM_W-1:0]       res_quot
);
  import csct_pkg::*;

  side_t             sd  [0:NUM_W];
  logic [XY_W-1:0]   rem [0:NUM_W];
  logic [NUM_W-1:0]  nq  [0:NUM_W];
  logic [XY_W-1:0]   den [0:NUM_W];

  assign sd[0]  = in_side;
  assign rem[0] = '0;
  assign nq[0]  = in_num;
  assign den[0] = in_den;

  for (genvar g = 0; g < NUM_W; g++) begin : g_stage
    logic [XY_W:0] trial;
    logic          fits;

    assign trial = {rem[g], nq[g][NUM_W-1]};
    assign fits  = trial >= {1'b0, den[g]};

    always_ff @(posedge clk) begin
      if (rst) begin
        sd[g+1].valid <= 1'b0;
      end else if (en) begin
        sd[g+1].valid <= sd[g].valid;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sd[g+1].kind   <= sd[g].kind;
        sd[g+1].q_neg  <= sd[g].q_neg;
        sd[g+1].x_zero <= sd[g].x_zero;
        sd[g+1].trig   <= sd[g].trig;
        den[g+1]       <= den[g];
        rem[g+1]       <= fits ? XY_W'(trial - {1'b0, den[g]}) : trial[XY_W-1:0];
        nq[g+1]        <= {nq[g][NUM_W-2:0], fits};
      end
    end
  end

  assign res_side = sd[NUM_W];
  assign res_quot = nq[NUM_W];

endmodule
`default_nettype wire

// ----- design/cordic_sin_cos_tan_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cordic_sin_cos_tan_unit
// Rotation-mode CORDIC giving sine, cosine or tangent of a reduced angle.
// ----------------------------------------------------------------------------
// The input channel takes kind, reduced_angle (Q3.29 radians) and negate on
// a beat with in_valid and in_ready both high. The output channel presents
// value, is_infinite and saturated with out_valid and completes on out_ready.
// Sine and cosine come back in Q2.30, tangent in Q16.16.
// Every beat follows the same path: one input register, ITERATIONS CORDIC
// stages, one preparation stage, a 50-stage restoring divider and one output
// register. One beat is accepted every cycle while the receiver takes
// results. When the receiver stalls, the whole pipeline holds in place and
// in_ready falls, so nothing is lost or repeated. Reset clears all valid
// bits; the unit is ready in the cycle after reset is released.
// ----------------------------------------------------------------------------
module cordic_sin_cos_tan_unit #(
  parameter int ITERATIONS = csct_pkg::ITERATIONS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         kind,
  input  wire logic signed [31:0] reduced_angle,
  input  wire logic               negate,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      value,
  output logic                    is_infinite,
  output logic                    saturated
);
  import csct_pkg::*;

  logic                   adv;
  logic                   c_valid;
  logic [1:0]             c_kind;
  logic                   c_negate;
  logic signed [XY_W-1:0] c_x;
  logic signed [XY_W-1:0] c_y;

  side_t                  side_next;
  side_t                  prep_side;
  logic [NUM_W-1:0]       prep_num;
  logic [XY_W-1:0]        prep_den;
  logic signed [XY_W:0]   trig_wide;
  logic [XY_W-1:0]        abs_y;
  logic [XY_W-1:0]        abs_x;

  side_t                  d_side;
  logic [NUM_W-1:0]       d_quot;

  logic signed [31:0]     value_next;
  logic                   is_infinite_next;
  logic                   saturated_next;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  csct_cordic #(.ITERATIONS(ITERATIONS)) u_cordic (
    .clk        (clk),
    .rst        (rst),
    .en         (adv),
    .in_valid   (in_valid),
    .in_kind    (kind),
    .in_angle   (reduced_angle),
    .in_negate  (negate),
    .res_valid  (c_valid),
    .res_kind   (c_kind),
    .res_negate (c_negate),
    .res_x      (c_x),
    .res_y      (c_y)
  );

  always_comb begin
    trig_wide = '0;
    if (c_kind == KIND_SIN) begin
      trig_wide = c_negate ? -(XY_W+1)'(c_y) : (XY_W+1)'(c_y);
    end else if (c_kind == KIND_COS) begin
      trig_wide = c_negate ? -(XY_W+1)'(c_x) : (XY_W+1)'(c_x);
    end
    abs_y = c_y[XY_W-1] ? XY_W'(-c_y) : c_y;
    abs_x = c_x[XY_W-1] ? XY_W'(-c_x) : c_x;

    side_next.valid  = c_valid;
    side_next.kind   = c_kind;
    side_next.q_neg  = c_y[XY_W-1] ^ c_x[XY_W-1] ^ c_negate;
    side_next.x_zero = (c_x == '0);
    if (trig_wide > (XY_W+1)'(I32_MAX)) begin
      side_next.trig = I32_MAX;
    end else if (trig_wide < (XY_W+1)'(I32_MIN)) begin
      side_next.trig = I32_MIN;
    end else begin
      side_next.trig = trig_wide[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prep_side.valid <= 1'b0;
    end else if (adv) begin
      prep_side.valid <= side_next.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prep_side.kind   <= side_next.kind;
      prep_side.q_neg  <= side_next.q_neg;
      prep_side.x_zero <= side_next.x_zero;
      prep_side.trig   <= side_next.trig;
      prep_num         <= {abs_y, 16'b0};
      prep_den         <= abs_x;
    end
  end

  csct_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_side  (prep_side),
    .in_num   (prep_num),
    .in_den   (prep_den),
    .res_side (d_side),
    .res_quot (d_quot)
  );

  always_comb begin
    value_next       = d_side.trig;
    is_infinite_next = 1'b0;
    saturated_next   = 1'b0;
    if (d_side.kind == KIND_TAN) begin
      if (d_side.x_zero) begin
        value_next       = I32_MAX;
        is_infinite_next = 1'b1;
      end else if (!d_side.q_neg) begin
        if (d_quot > NUM_W'(I32_MAX)) begin
          value_next     = I32_MAX;
          saturated_next = 1'b1;
        end else begin
          value_next = d_quot[31:0];
        end
      end else begin
        if (d_quot > (NUM_W'(1) << 31)) begin
          value_next     = I32_MIN;
          saturated_next = 1'b1;
        end else begin
          value_next = -d_quot[31:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= d_side.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      value       <= value_next;
      is_infinite <= is_infinite_next;
      saturated   <= saturated_next;
    end
  end

  a_ready_rule: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not follow the output stall");

  a_inf_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_infinite |-> !saturated && value == I32_MAX)
    else $error("infinite result carries a wrong value or flag");

  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |-> value == I32_MAX || value == I32_MIN)
    else $error("saturated result is not at a range limit");

  a_hold_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(value) && $stable(saturated))
    else $error("stalled result changed");

endmodule
`default_nettype wire

// ----- tb/sv/tb_cordic_sin_cos_tan_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cordic_sin_cos_tan_unit
// Self-checking bench for the CORDIC sine, cosine and tangent unit.
// ----------------------------------------------------------------------------
// Each accepted beat is run through a bit-exact CORDIC and divider model and
// the result is queued. Every output beat is compared field by field with the
// oldest queued result. The run covers directed corner angles, a long
// receiver stall, a full drain, random traffic with gaps on both sides, and
// a final stretch with no idling.
// ----------------------------------------------------------------------------
module tb_cordic_sin_cos_tan_unit;
  import csct_pkg::*;

  localparam int        NUM_STEPS = 30;
  localparam logic [1:0] KIND_NONE = 2'd3;
  localparam int        LATENCY   = NUM_STEPS + 53;
  localparam int        HOLD_LEN  = 400;
  localparam longint    CYCLE_LIMIT = 400000;
  localparam longint    HALF_PI_Q29 = 843314857;
  localparam longint    ATAN_TAB[31] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
    131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256,
    128, 64, 32, 16, 8, 4, 2, 1};

  typedef struct {
    logic signed [31:0] value;
    logic               is_infinite;
    logic               saturated;
  } trig_res_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         kind;
  logic signed [31:0] reduced_angle;
  logic               negate;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] value;
  logic               is_infinite;
  logic               saturated;

  trig_res_t pending_results[$];
  int        errors;
  int        beats_in;
  int        beats_out;
  int        tan_sat_seen;
  int        tan_inf_seen;
  longint    cycles;
  bit        gaps_on;
  bit        stalls_on;
  bit        hold_req;

  cordic_sin_cos_tan_unit #(.ITERATIONS(NUM_STEPS)) dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .reduced_angle(reduced_angle), .negate(negate),
    .out_valid(out_valid), .out_ready(out_ready), .value(value),
    .is_infinite(is_infinite), .saturated(saturated)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic longint clamp_i32(longint v, output bit hit);
    hit = 1'b0;
    if (v > 64'sd2147483647) begin
      hit = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      hit = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic trig_res_t predict_trig(logic [1:0] k, logic signed [31:0] a,
                                             logic n);
    longint    x;
    longint    y;
    longint    z;
    longint    dx;
    longint    dy;
    longint    q;
    bit        hit;
    trig_res_t r;
    x = 652032874;
    y = 0;
    z = longint'(a) * 2;
    for (int i = 0; i < NUM_STEPS && i < 31; i++) begin
      dx = x >>> i;
      dy = y >>> i;
      if (z >= 0) begin
        x = x - dy; y = y + dx; z = z - ATAN_TAB[i];
      end else begin
        x = x + dy; y = y - dx; z = z + ATAN_TAB[i];
      end
    end
    r.value = '0;
    r.is_infinite = 1'b0;
    r.saturated = 1'b0;
    case (k)
      KIND_SIN: r.value = 32'(clamp_i32(n ? -y : y, hit));
      KIND_COS: r.value = 32'(clamp_i32(n ? -x : x, hit));
      KIND_TAN: begin
        if (x == 0) begin
          r.value = I32_MAX;
          r.is_infinite = 1'b1;
        end else begin
          q = (y * 65536) / x;
          r.value = 32'(clamp_i32(n ? -q : q, hit));
          r.saturated = hit;
        end
      end
      default: r.value = '0;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      pending_results.push_back(predict_trig(kind, reduced_angle, negate));
      beats_in++;
    end
  end

  always @(posedge clk) begin
    trig_res_t e;
    if (!rst && out_valid && out_ready) begin
      beats_out++;
      if (pending_results.size() == 0) begin
        $error("Result beat arrived with nothing expected: value %0d", value);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (value !== e.value) begin
          $error("value: expected %0d, actual %0d", e.value, value);
          errors++;
        end
        if (is_infinite !== e.is_infinite) begin
          $error("is_infinite: expected %0b, actual %0b", e.is_infinite, is_infinite);
          errors++;
        end
        if (saturated !== e.saturated) begin
          $error("saturated: expected %0b, actual %0b", e.saturated, saturated);
          errors++;
        end
        if (e.saturated) tan_sat_seen++;
        if (e.is_infinite) tan_inf_seen++;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
        hold_req = 1'b0;
      end else if (stalls_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_beat(logic [1:0] k, logic signed [31:0] a, logic n);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    kind          <= k;
    reduced_angle <= a;
    negate        <= n;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic release_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_angle();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6)
      return 32'($signed($urandom_range(0, 2 * HALF_PI_Q29)) - HALF_PI_Q29);
    else if (sel < 8)
      return 32'(($urandom_range(0, 1) ? HALF_PI_Q29 : -HALF_PI_Q29)
                 + $signed($urandom_range(0, 4000)) - 2000);
    else
      return $signed($urandom());
  endfunction

  task automatic test_directed();
    logic signed [31:0] corners[10];
    corners = '{32'sd0, 32'sd1, -32'sd1, 32'(HALF_PI_Q29), -32'(HALF_PI_Q29),
                32'(HALF_PI_Q29 - 1), 32'sd421657428, I32_MAX, I32_MIN,
                32'sh55555555};
    gaps_on = 1'b0;
    foreach (corners[i]) begin
      send_beat(KIND_TAN, corners[i], i[0]);
      if (i < 5) send_beat(KIND_SIN, corners[i], i[1]);
      else send_beat(KIND_COS, corners[i], ~i[0]);
    end
    send_beat(KIND_NONE, 32'sh2AAAAAAA, 1'b1);
    send_beat(KIND_COS, -32'sd1, 1'b1);
    send_beat(KIND_SIN, 32'sh7FFFFFFF, 1'b1);
    release_input();
    wait_drained();
  endtask

  task automatic test_backpressure();
    gaps_on = 1'b0;
    hold_req = 1'b1;
    repeat (120) send_beat(2'($urandom_range(0, 2)), rand_angle(), 1'($urandom()));
    release_input();
  endtask

  task automatic test_drain();
    send_beat(KIND_TAN, 32'(HALF_PI_Q29), 1'b1);
    release_input();
    wait_drained();
  endtask

  task automatic test_random();
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    repeat (220) send_beat(2'($urandom_range(0, 2)), rand_angle(), 1'($urandom()));
    release_input();
  endtask

  task automatic test_no_idle();
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    repeat (40) send_beat(2'($urandom_range(0, 2)), rand_angle(), 1'($urandom()));
    release_input();
    wait_drained();
  endtask

  initial begin
    errors = 0;
    beats_in = 0;
    beats_out = 0;
    tan_sat_seen = 0;
    tan_inf_seen = 0;
    cycles = 0;
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    hold_req = 1'b0;
    rst <= 1'b1;
    in_valid <= 1'b0;
    kind <= KIND_SIN;
    reduced_angle <= '0;
    negate <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_drain();
    test_random();
    test_no_idle();
    $display("Covered %0d input beats and %0d results over %0d cycles.",
             beats_in, beats_out, cycles);
    $display("Tangent clamps seen: %0d, infinities seen: %0d.", tan_sat_seen, tan_inf_seen);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
